### hdl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// LPT scheduler package
// Field widths, request and result payload types and the shared unit's
// operation codes for the LPT machine scheduler.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int TIME_W    = 16;
  localparam int JOBNUM_W  = 6;
  localparam int MACHNUM_W = 5;
  localparam int LOAD_W    = 21;
  localparam int MCFG_W    = 5;

  // Loads saturate at the all-ones value of their field.
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  typedef enum logic [1:0] {
    ALU_GE  = 2'b01,
    ALU_ADD = 2'b10
  } alu_op_e;

  typedef struct packed {
    logic [TIME_W-1:0] job_time;
    logic              is_last_job;
  } job_req_t;

  typedef struct packed {
    logic [JOBNUM_W-1:0]  job_number;
    logic [TIME_W-1:0]    scheduled_time;
    logic [MACHNUM_W-1:0] machine_number;
    logic [LOAD_W-1:0]    machine_load;
    logic [LOAD_W-1:0]    makespan;
    logic                 overflow_flag;
    logic                 is_last_result;
  } sched_res_t;

endpackage

### hdl/lpt_stream_if.sv
// ----------------------------------------------------------------------------
// LPT scheduler stream interfaces
// Valid/ready channels for job requests and for schedule results.
// ----------------------------------------------------------------------------
interface lpt_job_if import lpt_pkg::*; ();
  logic     valid;
  logic     ready;
  job_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpt_res_if import lpt_pkg::*; ();
  logic       valid;
  logic       ready;
  sched_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/lpt_job_ram.sv
// ----------------------------------------------------------------------------
// LPT sorted job list memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lpt_job_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 21
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/lpt_load_ram.sv
// ----------------------------------------------------------------------------
// LPT machine load memory
// Per-machine accumulated load with registered read and per-entry valid
// bits; an entry that has not been written since the last clear reads zero.
// ----------------------------------------------------------------------------
module lpt_load_ram import lpt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     clr_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [LOAD_W-1:0]                        rd_data_o,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [LOAD_W-1:0]                        wr_data_i
);

  logic [LOAD_W-1:0] mem_q [DEPTH];
  logic [LOAD_W-1:0] rd_data_q;
  logic [DEPTH-1:0]  valid_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### hdl/lpt_alu.sv
// ----------------------------------------------------------------------------
// LPT shared arithmetic unit
// One unsigned comparator and one saturating adder, shared by the insertion
// walk, the minimum-load scan and the load and makespan update.
// ----------------------------------------------------------------------------
module lpt_alu import lpt_pkg::*; (
  input  alu_op_e           op_i,
  input  logic [LOAD_W-1:0] a_i,
  input  logic [LOAD_W-1:0] b_i,
  output logic              ge_o,
  output logic [LOAD_W-1:0] sum_o
);

  logic [LOAD_W:0] sum_raw;

  assign sum_raw = {1'b0, a_i} + {1'b0, b_i};

  always_comb begin
    ge_o  = 1'b0;
    sum_o = '0;
    unique case (op_i)
      ALU_GE: begin
        ge_o = (a_i >= b_i);
      end
      ALU_ADD: begin
        // A carry out means the sum passed the largest load.
        sum_o = sum_raw[LOAD_W] ? LOAD_MAX : sum_raw[LOAD_W-1:0];
      end
      default: begin
        ge_o  = 1'b0;
        sum_o = '0;
      end
    endcase
  end

endmodule

### hdl/lpt_machine_scheduler.sv
// ----------------------------------------------------------------------------
// LPT machine scheduler
// Collects a batch of job durations, keeps them in longest-first order and
// assigns each job to the least loaded machine, one result per job.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   job_i     in         valid/ready    job_time, is_last_job
//   res_o     out        valid/ready    job_number, scheduled_time,
//                                       machine_number, machine_load,
//                                       makespan, overflow_flag,
//                                       is_last_result
//   cfg       in         write enable   machine_count (5 bits)
//
// A job request is inserted by a walk from the list tail that moves past each
// entry no longer than the new job (at most the number of jobs held);
// the walk does one read and one write of the sorted list memory per cycle.
// A request that arrives with the list full is dropped when it is accepted.
// A marked request then starts the schedule: each job goes through a
// fetch, a scan over the machines, an add and an update step, where
// machines is the machine count after a zero count is raised to one and
// a large count is cut to MAX_MACHINES. The scan reads one machine load per
// cycle through the shared comparator; the update step waits while res_o
// holds back the result register.
// Reset is asynchronous and active low; no clearing pass is needed, since
// the load memory carries a valid bit per machine.
// job_i.ready is low while a request is inserted or a batch is scheduled.
// ----------------------------------------------------------------------------
module lpt_machine_scheduler import lpt_pkg::*; #(
  parameter int MAX_JOBS     = 32,
  parameter int MAX_MACHINES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MCFG_W-1:0] cfg_data_i,
  lpt_job_if.sink           job_i,
  lpt_res_if.source         res_o
);

  localparam int IDX_W  = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int MIDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MCNT_W = $clog2(MAX_MACHINES + 1);
  localparam int ENT_W  = TIME_W + IDX_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JOBS);

  // One entry of the sorted list: duration and zero-based arrival index.
  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_FETCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ADD   = 6'b010000,
    S_UPD   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Batch control.
  logic [MCFG_W-1:0] mcount_q;
  logic [CNT_W-1:0]  count_q;
  logic              dropped_q;
  logic              last_q;
  logic [CNT_W-1:0]  pos_q;
  logic [IDX_W-1:0]  k_q;
  logic [MCNT_W-1:0] machines_q;
  logic [MIDX_W-1:0] cmp_m_q;
  logic              res_valid_q;

  // Datapath registers.
  logic [TIME_W-1:0] new_time_q;
  logic [LOAD_W-1:0] best_q;
  logic [MIDX_W-1:0] best_idx_q;
  logic [LOAD_W-1:0] new_load_q;
  logic [LOAD_W-1:0] makespan_q;
  sched_res_t        res_q;
  sched_res_t        res_d;

  // Memory and shared unit hookup.
  logic              jr_wr_en, jr_rd_en;
  logic [IDX_W-1:0]  jr_wr_addr, jr_rd_addr;
  entry_t            jr_wr_ent;
  logic [ENT_W-1:0]  jr_rd_data;
  entry_t            jr_rd_ent;

  logic              lr_clr, lr_rd_en, lr_wr_en;
  logic [MIDX_W-1:0] lr_rd_addr;
  logic [LOAD_W-1:0] lr_rd_data;

  alu_op_e           alu_op;
  logic [LOAD_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_ge;

  logic              job_acc;
  logic              out_free;
  logic              ins_shift;
  logic              start_sched;
  logic              scan_done;
  logic              batch_end;
  logic              scan_take;
  logic [MCNT_W-1:0] machines_sat;

  assign jr_rd_ent = jr_rd_data;

  assign job_i.ready = (state_q == S_IDLE);
  assign job_acc     = job_i.valid && job_i.ready;

  // The result register can take a new result when it is empty or is being
  // drained in this cycle.
  assign out_free    = !res_valid_q || res_o.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // A new job moves past a list entry when it is at least as long: on equal
  // durations the later arrival goes first.
  assign ins_shift = (state_q == S_INS) && (pos_q != '0) && alu_ge;

  assign start_sched = (job_acc && (count_q == CNT_FULL) && job_i.data.is_last_job) ||
                       ((state_q == S_INS) && !ins_shift && last_q);

  assign scan_done = ((MCNT_W'(cmp_m_q) + MCNT_W'(1)) == machines_q);
  assign batch_end = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

  // A lower load replaces the best so far; ties keep the lower machine.
  assign scan_take = (cmp_m_q == '0) || !alu_ge;

  // Machine count zero acts as one machine; large counts saturate.
  always_comb begin
    if (mcount_q == '0) begin
      machines_sat = MCNT_W'(1);
    end else if (32'(mcount_q) > MAX_MACHINES) begin
      machines_sat = MCNT_W'(MAX_MACHINES);
    end else begin
      machines_sat = MCNT_W'(mcount_q);
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_GE;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_INS: begin
        alu_a = LOAD_W'(new_time_q);
        alu_b = LOAD_W'(jr_rd_ent.t);
      end
      S_SCAN: begin
        alu_a = lr_rd_data;
        alu_b = best_q;
      end
      S_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = best_q;
        alu_b  = LOAD_W'(jr_rd_ent.t);
      end
      S_UPD: begin
        alu_a = new_load_q;
        alu_b = makespan_q;
      end
      default: begin
        alu_op = ALU_GE;
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    jr_wr_en   = 1'b0;
    jr_wr_addr = IDX_W'(pos_q);
    jr_wr_ent  = jr_rd_ent;
    jr_rd_en   = 1'b0;
    jr_rd_addr = IDX_W'(count_q - CNT_W'(1));
    lr_clr     = start_sched;
    lr_rd_en   = 1'b0;
    lr_rd_addr = '0;
    lr_wr_en   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // Fetch the current tail so the walk can compare in the next cycle.
        jr_rd_en = job_acc && (count_q != CNT_FULL);
      end
      S_INS: begin
        jr_wr_en = 1'b1;
        if (ins_shift) begin
          jr_rd_en   = 1'b1;
          jr_rd_addr = IDX_W'(pos_q - CNT_W'(2));
        end else begin
          jr_wr_ent.t   = new_time_q;
          jr_wr_ent.idx = IDX_W'(count_q - CNT_W'(1));
        end
      end
      S_FETCH: begin
        jr_rd_en   = 1'b1;
        jr_rd_addr = k_q;
        lr_rd_en   = 1'b1;
      end
      S_SCAN: begin
        lr_rd_en   = !scan_done;
        lr_rd_addr = MIDX_W'(cmp_m_q + MIDX_W'(1));
      end
      S_ADD: begin
        lr_rd_en = 1'b0;
      end
      S_UPD: begin
        lr_wr_en = out_free;
      end
      default: begin
        jr_rd_en = 1'b0;
      end
    endcase
  end

  // Next result, formed in the update cycle.
  always_comb begin
    res_d.job_number     = JOBNUM_W'({1'b0, jr_rd_ent.idx} + (IDX_W + 1)'(1));
    res_d.scheduled_time = jr_rd_ent.t;
    res_d.machine_number = MACHNUM_W'({1'b0, best_idx_q} + (MIDX_W + 1)'(1));
    res_d.machine_load   = new_load_q;
    res_d.makespan       = alu_ge ? new_load_q : makespan_q;
    res_d.overflow_flag  = dropped_q;
    res_d.is_last_result = batch_end;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_acc) begin
          if (count_q != CNT_FULL) begin
            state_d = S_INS;
          end else if (job_i.data.is_last_job) begin
            state_d = S_FETCH;
          end
        end
      end
      S_INS: begin
        if (!ins_shift) begin
          state_d = last_q ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_d = batch_end ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcount_q    <= MCFG_W'(1);
      count_q     <= '0;
      dropped_q   <= 1'b0;
      last_q      <= 1'b0;
      pos_q       <= '0;
      k_q         <= '0;
      machines_q  <= MCNT_W'(1);
      cmp_m_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mcount_q <= cfg_data_i;
      end
      if (start_sched) begin
        k_q        <= '0;
        machines_q <= machines_sat;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_acc) begin
            last_q <= job_i.data.is_last_job;
            if (count_q != CNT_FULL) begin
              count_q <= count_q + CNT_W'(1);
              pos_q   <= count_q;
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        S_INS: begin
          if (ins_shift) begin
            pos_q <= pos_q - CNT_W'(1);
          end
        end
        S_FETCH: begin
          cmp_m_q <= '0;
        end
        S_SCAN: begin
          if (!scan_done) begin
            cmp_m_q <= cmp_m_q + MIDX_W'(1);
          end
        end
        S_ADD: begin
          cmp_m_q <= cmp_m_q;
        end
        S_UPD: begin
          if (out_free) begin
            if (batch_end) begin
              // The next request opens a new batch.
              count_q   <= '0;
              dropped_q <= 1'b0;
            end else begin
              k_q <= k_q + IDX_W'(1);
            end
          end
        end
        default: begin
          cmp_m_q <= '0;
        end
      endcase
      if ((state_q == S_UPD) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_acc) begin
      new_time_q <= job_i.data.job_time;
    end
    if (start_sched) begin
      makespan_q <= '0;
    end
    if ((state_q == S_SCAN) && scan_take) begin
      best_q     <= lr_rd_data;
      best_idx_q <= cmp_m_q;
    end
    if (state_q == S_ADD) begin
      new_load_q <= alu_sum;
    end
    if ((state_q == S_UPD) && out_free) begin
      makespan_q <= res_d.makespan;
      res_q      <= res_d;
    end
  end

  lpt_job_ram #(
    .DEPTH (MAX_JOBS),
    .WIDTH (ENT_W)
  ) u_job_ram (
    .clk_i     (clk_i),
    .wr_en_i   (jr_wr_en),
    .wr_addr_i (jr_wr_addr),
    .wr_data_i (jr_wr_ent),
    .rd_en_i   (jr_rd_en),
    .rd_addr_i (jr_rd_addr),
    .rd_data_o (jr_rd_data)
  );

  lpt_load_ram #(
    .DEPTH (MAX_MACHINES)
  ) u_load_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (lr_clr),
    .rd_en_i   (lr_rd_en),
    .rd_addr_i (lr_rd_addr),
    .rd_data_o (lr_rd_data),
    .wr_en_i   (lr_wr_en),
    .wr_addr_i (best_idx_q),
    .wr_data_i (new_load_q)
  );

  lpt_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ge_o  (alu_ge),
    .sum_o (alu_sum)
  );

endmodule

### hdl/lpt_chk.sv
// ----------------------------------------------------------------------------
// LPT scheduler port checker
// Watches the scheduler's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lpt_chk import lpt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input sched_res_t out_data_i
);

  // A pending result stays offered until it is taken.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before it was taken");

  // A stalled result does not change.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  // A marked job starts scheduling, so no request is taken right after it.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("job request taken while a batch is being scheduled");

  // The makespan is the largest load so far, and a load holds its own job.
  a_load_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.machine_load <= out_data_i.makespan) &&
                    (LOAD_W'(out_data_i.scheduled_time) <= out_data_i.machine_load))
    else $error("machine load outside its bounds");

endmodule

bind lpt_machine_scheduler lpt_chk u_lpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (job_i.valid),
  .in_ready_i  (job_i.ready),
  .in_last_i   (job_i.data.is_last_job),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
